// File: rtl/sst_pkg.sv
package sst_pkg;

  localparam int TOKEN_LIMIT = 4096;
  localparam int TEMIT_W = $clog2(TOKEN_LIMIT + 1);
  localparam logic [6:0] STRING_MAX = 7'd127;
  localparam logic [6:0] STRLEN_SAT = 7'd127;
  localparam int KW_COUNT = 42;
  localparam int KW_BOOL_IDX = 35;
  localparam int KW_TRUE_IDX = 35;
  localparam int RES_MAX = 3;

  typedef enum logic [6:0] {
    K_LET, K_CONST, K_FUNCTION, K_RETURN, K_IF, K_ELSE, K_LOOP, K_FROM, K_TO,
    K_WHILE, K_BREAK, K_CONTINUE, K_PRINT, K_INPUT, K_TRY, K_CATCH, K_THROW,
    K_PARALLEL, K_TASK, K_USE, K_SYSTEM, K_UI, K_WINDOW, K_BUTTON, K_LABEL,
    K_SERVER, K_ROUTE, K_START, K_CREATE, K_WRITE, K_READ, K_FILE, K_REWIND,
    K_STEP, K_REPLAY, K_BOOL, K_NULL, K_AND, K_OR, K_NOT, K_STR, K_IDENT,
    K_NEWLINE, K_STRING, K_FLOAT, K_INT, K_EQ, K_NEQ, K_LTE, K_GTE,
    K_PLUS_ASSIGN, K_MINUS_ASSIGN, K_ERROR, K_PLUS, K_MINUS, K_STAR, K_SLASH,
    K_PERCENT, K_ASSIGN, K_LT, K_GT, K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE,
    K_LBRACKET, K_RBRACKET, K_COMMA, K_DOT, K_COLON, K_SEMICOLON, K_EOF
  } kind_t;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LTT = 8'h74;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "let", "const", "function", "return", "if", "else", "loop", "from", "to",
    "while", "break", "continue", "print", "input", "try", "catch", "throw",
    "parallel", "task", "use", "system", "ui", "window", "button", "label",
    "server", "route", "start", "create", "write", "read", "file", "rewind",
    "step", "replay", "true", "false", "null", "and", "or", "not", "str"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd8, 4'd6, 4'd2, 4'd4, 4'd4, 4'd4, 4'd2,
    4'd5, 4'd5, 4'd8, 4'd5, 4'd5, 4'd3, 4'd5, 4'd5,
    4'd8, 4'd4, 4'd3, 4'd6, 4'd2, 4'd6, 4'd6, 4'd5,
    4'd6, 4'd5, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd6,
    4'd4, 4'd6, 4'd4, 4'd5, 4'd4, 4'd3, 4'd2, 4'd3, 4'd3
  };

  typedef struct packed {
    logic        is_text;
    logic [6:0]  token_kind;
    logic [7:0]  text_byte;
    logic [31:0] int_value;
    logic [15:0] line_number;
    logic [23:0] start_offset;
    logic [11:0] span_length;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0]  count;
    res_t [2:0]  res;
  } batch_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    logic [3:0] len;
    logic [3:0] ii;
    len = KW_LEN[k];
    ii = {1'b0, i};
    if (ii < len) begin
      kw_char = KW_TEXT[k][8 * (len - ii - 4'd1) +: 8];
    end else begin
      kw_char = CH_NUL;
    end
  endfunction

  function automatic logic [11:0] span_of(input logic [23:0] s, input logic [24:0] e);
    logic [24:0] d;
    d = e - {1'b0, s};
    if (e <= {1'b0, s}) begin
      span_of = 12'd0;
    end else if (d > 25'd4095) begin
      span_of = 12'd4095;
    end else begin
      span_of = d[11:0];
    end
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    is_alp = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             (c == CH_UNDER);
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    may_pair = (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_AMP) || (c == CH_BAR) ||
               (c == CH_SLASH);
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:     single_kind = K_PLUS;
      CH_MINUS:    single_kind = K_MINUS;
      CH_STAR:     single_kind = K_STAR;
      CH_SLASH:    single_kind = K_SLASH;
      CH_PERCENT:  single_kind = K_PERCENT;
      CH_EQ:       single_kind = K_ASSIGN;
      CH_LT:       single_kind = K_LT;
      CH_GT:       single_kind = K_GT;
      CH_BANG:     single_kind = K_NOT;
      CH_LPAREN:   single_kind = K_LPAREN;
      CH_RPAREN:   single_kind = K_RPAREN;
      CH_LBRACE:   single_kind = K_LBRACE;
      CH_RBRACE:   single_kind = K_RBRACE;
      CH_LBRACKET: single_kind = K_LBRACKET;
      CH_RBRACKET: single_kind = K_RBRACKET;
      CH_COMMA:    single_kind = K_COMMA;
      CH_DOT:      single_kind = K_DOT;
      CH_COLON:    single_kind = K_COLON;
      CH_SEMI:     single_kind = K_SEMICOLON;
      default:     single_kind = K_ERROR;
    endcase
  endfunction

endpackage

// File: rtl/sst_scan.sv
module sst_scan import sst_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   source_byte,
  output batch_t       batch
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_STRING, M_ESCAPE, M_STRFULL, M_HELD, M_INTEGER,
    M_INTDOT, M_FLOAT, M_WORD
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [15:0]         line_r, line_nxt;
  logic [23:0]         off_r, off_nxt;
  logic [23:0]         tbeg_r, tbeg_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [7:0]          held_r, held_nxt;
  logic [KW_COUNT-1:0] alive_r, alive_nxt;
  logic [11:0]         wlen_r, wlen_nxt;
  logic [6:0]          slen_r, slen_nxt;
  logic [TEMIT_W-1:0]  temit_r, temit_nxt;

  res_t                cand [RES_MAX];
  logic [1:0]          nc;
  logic                do_fresh;
  logic                restart;
  logic [7:0]          b;
  logic [23:0]         pos;
  logic [23:0]         prevp;
  logic [24:0]         pos1;
  logic [7:0]          d;
  logic [6:0]          wkind;
  logic [31:0]         wval;
  logic                pk_ok;
  kind_t               pk;
  logic [TEMIT_W-1:0]  te;
  logic [1:0]          n;
  res_t [2:0]          outres;

  always_comb begin
    b = source_byte;
    pos = off_r;
    prevp = (off_r == 24'd0) ? 24'd0 : off_r - 24'd1;
    pos1 = {1'b0, off_r} + 25'd1;
    mode_nxt = mode_r;
    line_nxt = line_r;
    tbeg_nxt = tbeg_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    held_nxt = held_r;
    alive_nxt = alive_r;
    wlen_nxt = wlen_r;
    slen_nxt = slen_r;
    nc = 2'd0;
    do_fresh = 1'b0;
    restart = 1'b0;
    d = b;
    wkind = K_IDENT;
    wval = 32'd0;
    pk_ok = 1'b0;
    pk = K_ERROR;
    for (int i = 0; i < RES_MAX; i++) begin
      cand[i] = '0;
    end

    case (mode_r)
      M_COMMENT: begin
        if (b == CH_LF || b == CH_NUL) do_fresh = 1'b1;
      end
      M_STRING, M_ESCAPE: begin
        if (b == CH_NUL) begin
          cand[nc] = '{1'b0, K_STRING, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end else if (mode_r == M_STRING && b == CH_QUOTE) begin
          cand[nc] = '{1'b0, K_STRING, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, pos1), 1'b0};
          nc = nc + 2'd1;
          mode_nxt = M_IDLE;
        end else if (mode_r == M_STRING && b == CH_BSLASH) begin
          mode_nxt = M_ESCAPE;
        end else begin
          if (mode_r == M_ESCAPE) begin
            d = (b == CH_LN) ? CH_LF : ((b == CH_LTT) ? CH_TAB : b);
          end
          cand[nc] = '{1'b1, K_STRING, d, 32'd0, line_r,
                       (mode_r == M_ESCAPE) ? prevp : pos,
                       span_of((mode_r == M_ESCAPE) ? prevp : pos, pos1), 1'b0};
          nc = nc + 2'd1;
          if (slen_r < STRLEN_SAT) slen_nxt = slen_r + 7'd1;
          mode_nxt = (slen_nxt >= STRING_MAX) ? M_STRFULL : M_STRING;
        end
      end
      M_STRFULL: begin
        if (b == CH_QUOTE) begin
          cand[nc] = '{1'b0, K_STRING, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, pos1), 1'b0};
          nc = nc + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          cand[nc] = '{1'b0, K_STRING, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      M_HELD: begin
        if (b == CH_EQ) begin
          pk_ok = 1'b1;
          case (held_r)
            CH_EQ:    pk = K_EQ;
            CH_BANG:  pk = K_NEQ;
            CH_LT:    pk = K_LTE;
            CH_GT:    pk = K_GTE;
            CH_PLUS:  pk = K_PLUS_ASSIGN;
            CH_MINUS: pk = K_MINUS_ASSIGN;
            default:  pk_ok = 1'b0;
          endcase
        end else if (held_r == CH_AMP && b == CH_AMP) begin
          pk_ok = 1'b1;
          pk = K_AND;
        end else if (held_r == CH_BAR && b == CH_BAR) begin
          pk_ok = 1'b1;
          pk = K_OR;
        end
        if (held_r == CH_SLASH && b == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else if (held_r == CH_MINUS && is_dig(b)) begin
          mode_nxt = M_INTEGER;
          neg_nxt = 1'b1;
          acc_nxt = {28'd0, b[3:0]};
        end else if (pk_ok) begin
          cand[nc] = '{1'b0, pk, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, pos1), 1'b0};
          nc = nc + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          cand[nc] = '{1'b0, single_kind(held_r), 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      M_INTEGER: begin
        if (is_dig(b)) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, b[3:0]};
        end else if (b == CH_DOT) begin
          mode_nxt = M_INTDOT;
        end else begin
          cand[nc] = '{1'b0, K_INT, 8'd0, neg_r ? (32'd0 - acc_r) : acc_r, line_r,
                       tbeg_r, span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      M_INTDOT: begin
        if (is_dig(b)) begin
          mode_nxt = M_FLOAT;
        end else begin
          cand[nc] = '{1'b0, K_INT, 8'd0, neg_r ? (32'd0 - acc_r) : acc_r, line_r,
                       tbeg_r, span_of(tbeg_r, {1'b0, prevp}), 1'b0};
          nc = nc + 2'd1;
          cand[nc] = '{1'b0, K_DOT, 8'd0, 32'd0, line_r, prevp,
                       span_of(prevp, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      M_FLOAT: begin
        if (!is_dig(b)) begin
          cand[nc] = '{1'b0, K_FLOAT, 8'd0, 32'd0, line_r, tbeg_r,
                       span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      M_WORD: begin
        if (is_alp(b) || is_dig(b)) begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (wlen_r >= 12'd8 || kw_char(k, wlen_r[2:0]) != b) alive_nxt[k] = 1'b0;
          end
          if (wlen_r < 12'd4095) wlen_nxt = wlen_r + 12'd1;
        end else begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (alive_r[k] && {8'd0, KW_LEN[k]} == wlen_r) begin
              wkind = (k <= KW_BOOL_IDX) ? 7'(k) : 7'(k - 1);
              wval = (k == KW_TRUE_IDX) ? 32'd1 : 32'd0;
            end
          end
          cand[nc] = '{1'b0, wkind, 8'd0, wval, line_r, tbeg_r,
                       span_of(tbeg_r, {1'b0, pos}), 1'b0};
          nc = nc + 2'd1;
          do_fresh = 1'b1;
        end
      end
      default: do_fresh = 1'b1;
    endcase

    if (do_fresh) begin
      mode_nxt = M_IDLE;
      tbeg_nxt = pos;
      if (b == CH_NUL) begin
        cand[nc] = '{1'b0, K_EOF, 8'd0, 32'd0, line_r, pos, 12'd0, 1'b0};
        nc = nc + 2'd1;
        restart = 1'b1;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
        mode_nxt = M_IDLE;
      end else if (b == CH_LF) begin
        cand[nc] = '{1'b0, K_NEWLINE, 8'd0, 32'd0, line_r, pos, 12'd1, 1'b0};
        nc = nc + 2'd1;
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
      end else if (b == CH_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (b == CH_QUOTE) begin
        mode_nxt = M_STRING;
        slen_nxt = 7'd0;
      end else if (is_dig(b)) begin
        mode_nxt = M_INTEGER;
        neg_nxt = 1'b0;
        acc_nxt = {28'd0, b[3:0]};
      end else if (is_alp(b)) begin
        mode_nxt = M_WORD;
        for (int k = 0; k < KW_COUNT; k++) begin
          alive_nxt[k] = (kw_char(k, 3'd0) == b);
        end
        wlen_nxt = 12'd1;
      end else if (may_pair(b)) begin
        mode_nxt = M_HELD;
        held_nxt = b;
      end else begin
        cand[nc] = '{1'b0, single_kind(b), 8'd0, 32'd0, line_r, pos, 12'd1, 1'b0};
        nc = nc + 2'd1;
      end
    end

    te = temit_r;
    n = 2'd0;
    outres = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < nc && te < TEMIT_W'(TOKEN_LIMIT)) begin
        outres[n] = cand[i];
        n = n + 2'd1;
        if (!cand[i].is_text) te = te + TEMIT_W'(1);
      end
    end
    if (n != 2'd0) outres[n - 2'd1].last_of_run = 1'b1;
    temit_nxt = te;
    off_nxt = (off_r != 24'hFFFFFF) ? off_r + 24'd1 : off_r;

    if (restart) begin
      mode_nxt = M_IDLE;
      line_nxt = 16'd1;
      off_nxt = 24'd0;
      tbeg_nxt = 24'd0;
      acc_nxt = 32'd0;
      neg_nxt = 1'b0;
      held_nxt = 8'd0;
      alive_nxt = '1;
      wlen_nxt = 12'd0;
      slen_nxt = 7'd0;
      temit_nxt = '0;
    end

    batch.count = n;
    batch.res = outres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= 16'd1;
      off_r <= 24'd0;
      tbeg_r <= 24'd0;
      acc_r <= 32'd0;
      neg_r <= 1'b0;
      held_r <= 8'd0;
      alive_r <= '1;
      wlen_r <= 12'd0;
      slen_r <= 7'd0;
      temit_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      off_r <= off_nxt;
      tbeg_r <= tbeg_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      held_r <= held_nxt;
      alive_r <= alive_nxt;
      wlen_r <= wlen_nxt;
      slen_r <= slen_nxt;
      temit_r <= temit_nxt;
    end
  end

endmodule

// File: rtl/sst_outq.sv
module sst_outq import sst_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  batch_t batch,
  output logic   can_load,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   head
);

  res_t       slot_r [RES_MAX];
  logic [1:0] cnt_r;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign head = slot_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // hold results; shift toward the head on each pop
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_MAX; i++) begin
        slot_r[i] <= batch.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        slot_r[i] <= slot_r[i + 1];
      end
    end
  end

endmodule

// File: rtl/script_source_tokenizer_top.sv
// channel | ports                                  | word
// in      | in_valid, in_ready                     | in_source_byte
// out     | out_valid, out_ready                   | out_is_text .. out_last_of_run
// One byte is taken per cycle while in_ready is high; its results appear in the output
// register the next cycle. A byte with several results holds off the next byte while
// the three-entry result register drains, one word per cycle whenever out_ready is high.
// Reset (rst_n low, synchronous) returns the scanner to line 1, offset 0.
// A stalled out_ready blocks input whenever a result is pending.
module script_source_tokenizer_top import sst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_source_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_text,
  output logic [6:0]         out_token_kind,
  output logic [7:0]         out_text_byte,
  output logic signed [31:0] out_int_value,
  output logic [15:0]        out_line_number,
  output logic [23:0]        out_start_offset,
  output logic [11:0]        out_span_length,
  output logic               out_last_of_run
);

  batch_t batch;
  res_t   head;
  logic   accept;

  assign accept = in_valid && in_ready;

  sst_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .source_byte (in_source_byte),
    .batch       (batch)
  );

  sst_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .batch     (batch),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_is_text = head.is_text;
  assign out_token_kind = head.token_kind;
  assign out_text_byte = head.text_byte;
  assign out_int_value = head.int_value;
  assign out_line_number = head.line_number;
  assign out_start_offset = head.start_offset;
  assign out_span_length = head.span_length;
  assign out_last_of_run = head.last_of_run;

endmodule

// File: rtl/sst_checker.sv
module sst_checker import sst_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_text,
  input logic [6:0]  out_token_kind,
  input logic [15:0] out_line_number,
  input logic [11:0] out_span_length,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("result word changed while stalled");

  a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_text |-> out_token_kind == K_STRING)
    else $error("text word not tagged as string");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_text && out_token_kind == K_EOF |->
      out_last_of_run && out_span_length == 12'd0)
    else $error("end token not last or not empty");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 16'd0)
    else $error("line number zero");

  a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result pending");

endmodule

bind script_source_tokenizer_top sst_checker u_sst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_is_text     (out_is_text),
  .out_token_kind  (out_token_kind),
  .out_line_number (out_line_number),
  .out_span_length (out_span_length),
  .out_last_of_run (out_last_of_run)
);

// File: tb/token_checker.sv
module token_checker import sst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_source_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_is_text,
  input  logic [6:0]         out_token_kind,
  input  logic [7:0]         out_text_byte,
  input  logic signed [31:0] out_int_value,
  input  logic [15:0]        out_line_number,
  input  logic [23:0]        out_start_offset,
  input  logic [11:0]        out_span_length,
  input  logic               out_last_of_run,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_STRING, SCAN_ESCAPE, SCAN_STRFULL, SCAN_HELD,
    SCAN_INTEGER, SCAN_INTDOT, SCAN_FLOAT, SCAN_WORD
  } scan_t;

  scan_t       mode;
  int unsigned line_c, offs, tbeg, wlen, slen, ntok;
  logic [31:0] accum;
  bit          neg;
  logic [7:0]  held;
  logic [63:0] wbuf;

  res_t        step_res [3];
  int          nstep;
  bit          restart;
  res_t        expected_words [$];

  assign pending = expected_words.size();

  function automatic void clear_scan();
    mode = SCAN_IDLE;
    line_c = 1;
    offs = 0;
    tbeg = 0;
    accum = '0;
    neg = 0;
    held = '0;
    wbuf = '0;
    wlen = 0;
    slen = 0;
    ntok = 0;
  endfunction

  function automatic void emit(bit txt, kind_t kind, logic [7:0] tb, logic [31:0] ival,
                               int unsigned start, int unsigned stop);
    res_t r;
    int unsigned span;
    if (ntok >= TOKEN_LIMIT || nstep >= 3) return;
    if (!txt) ntok++;
    span = stop > start ? stop - start : 0;
    if (span > 4095) span = 4095;
    r.is_text = txt;
    r.token_kind = kind;
    r.text_byte = tb;
    r.int_value = ival;
    r.line_number = line_c[15:0];
    r.start_offset = start[23:0];
    r.span_length = span[11:0];
    r.last_of_run = 1'b0;
    step_res[nstep] = r;
    nstep++;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
  endfunction

  function automatic kind_t lone_kind(logic [7:0] c);
    case (c)
      CH_PLUS:     return K_PLUS;
      CH_MINUS:    return K_MINUS;
      CH_STAR:     return K_STAR;
      CH_SLASH:    return K_SLASH;
      CH_PERCENT:  return K_PERCENT;
      CH_EQ:       return K_ASSIGN;
      CH_LT:       return K_LT;
      CH_GT:       return K_GT;
      CH_BANG:     return K_NOT;
      CH_LPAREN:   return K_LPAREN;
      CH_RPAREN:   return K_RPAREN;
      CH_LBRACE:   return K_LBRACE;
      CH_RBRACE:   return K_RBRACE;
      CH_LBRACKET: return K_LBRACKET;
      CH_RBRACKET: return K_RBRACKET;
      CH_COMMA:    return K_COMMA;
      CH_DOT:      return K_DOT;
      CH_COLON:    return K_COLON;
      CH_SEMI:     return K_SEMICOLON;
      default:     return K_ERROR;
    endcase
  endfunction

  function automatic bit pairable(logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT || c == CH_PLUS ||
           c == CH_MINUS || c == CH_AMP || c == CH_BAR || c == CH_SLASH;
  endfunction

  function automatic void word_add(logic [7:0] c);
    if (wlen < 8) wbuf = {wbuf[55:0], c};
    if (wlen < 4095) wlen++;
  endfunction

  function automatic void word_done(int unsigned stop);
    kind_t kind;
    logic [31:0] val;
    kind = K_IDENT;
    val = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (wlen == KW_LEN[k] && wbuf == KW_TEXT[k]) begin
        kind = kind_t'(k <= KW_BOOL_IDX ? k : k - 1);
        val = (k == KW_TRUE_IDX) ? 32'd1 : 32'd0;
      end
    end
    emit(0, kind, '0, val, tbeg, stop);
  endfunction

  function automatic void int_done(int unsigned stop);
    emit(0, K_INT, '0, neg ? 32'd0 - accum : accum, tbeg, stop);
  endfunction

  function automatic void text_add(logic [7:0] d, int unsigned start, int unsigned stop);
    emit(1, K_STRING, d, '0, start, stop);
    if (slen < 127) slen++;
    mode = (slen >= STRING_MAX) ? SCAN_STRFULL : SCAN_STRING;
  endfunction

  function automatic void start_token(logic [7:0] b, int unsigned pos);
    mode = SCAN_IDLE;
    tbeg = pos;
    if (b == CH_NUL) begin
      emit(0, K_EOF, '0, '0, pos, pos);
      restart = 1;
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
    end else if (b == CH_LF) begin
      emit(0, K_NEWLINE, '0, '0, pos, pos + 1);
      if (line_c < 65535) line_c++;
    end else if (b == CH_HASH) begin
      mode = SCAN_COMMENT;
    end else if (b == CH_QUOTE) begin
      mode = SCAN_STRING;
      slen = 0;
    end else if (digit(b)) begin
      mode = SCAN_INTEGER;
      neg = 0;
      accum = 32'(b - CH_0);
    end else if (alpha(b)) begin
      mode = SCAN_WORD;
      wbuf = '0;
      wlen = 0;
      word_add(b);
    end else if (pairable(b)) begin
      mode = SCAN_HELD;
      held = b;
    end else begin
      emit(0, lone_kind(b), '0, '0, pos, pos + 1);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    int unsigned pos, prev;
    logic [7:0] d;
    pos = offs;
    prev = offs != 0 ? offs - 1 : 0;
    nstep = 0;
    restart = 0;
    case (mode)
      SCAN_COMMENT: begin
        if (b == CH_LF || b == CH_NUL) start_token(b, pos);
      end
      SCAN_STRING: begin
        if (b == CH_NUL) begin
          emit(0, K_STRING, '0, '0, tbeg, pos);
          start_token(b, pos);
        end else if (b == CH_QUOTE) begin
          emit(0, K_STRING, '0, '0, tbeg, pos + 1);
          mode = SCAN_IDLE;
        end else if (b == CH_BSLASH) begin
          mode = SCAN_ESCAPE;
        end else begin
          text_add(b, pos, pos + 1);
        end
      end
      SCAN_ESCAPE: begin
        if (b == CH_NUL) begin
          emit(0, K_STRING, '0, '0, tbeg, pos);
          start_token(b, pos);
        end else begin
          d = (b == CH_LN) ? CH_LF : (b == CH_LTT) ? CH_TAB : b;
          text_add(d, prev, pos + 1);
        end
      end
      SCAN_STRFULL: begin
        if (b == CH_QUOTE) begin
          emit(0, K_STRING, '0, '0, tbeg, pos + 1);
          mode = SCAN_IDLE;
        end else begin
          emit(0, K_STRING, '0, '0, tbeg, pos);
          start_token(b, pos);
        end
      end
      SCAN_HELD: begin
        if (held == CH_SLASH && b == CH_SLASH) begin
          mode = SCAN_COMMENT;
        end else if (held == CH_MINUS && digit(b)) begin
          mode = SCAN_INTEGER;
          neg = 1;
          accum = 32'(b - CH_0);
        end else if (b == CH_EQ && (held == CH_EQ || held == CH_BANG || held == CH_LT ||
                     held == CH_GT || held == CH_PLUS || held == CH_MINUS)) begin
          case (held)
            CH_EQ:   emit(0, K_EQ, '0, '0, tbeg, pos + 1);
            CH_BANG: emit(0, K_NEQ, '0, '0, tbeg, pos + 1);
            CH_LT:   emit(0, K_LTE, '0, '0, tbeg, pos + 1);
            CH_GT:   emit(0, K_GTE, '0, '0, tbeg, pos + 1);
            CH_PLUS: emit(0, K_PLUS_ASSIGN, '0, '0, tbeg, pos + 1);
            default: emit(0, K_MINUS_ASSIGN, '0, '0, tbeg, pos + 1);
          endcase
          mode = SCAN_IDLE;
        end else if (held == CH_AMP && b == CH_AMP) begin
          emit(0, K_AND, '0, '0, tbeg, pos + 1);
          mode = SCAN_IDLE;
        end else if (held == CH_BAR && b == CH_BAR) begin
          emit(0, K_OR, '0, '0, tbeg, pos + 1);
          mode = SCAN_IDLE;
        end else begin
          emit(0, lone_kind(held), '0, '0, tbeg, pos);
          start_token(b, pos);
        end
      end
      SCAN_INTEGER: begin
        if (digit(b)) accum = accum * 32'd10 + 32'(b - CH_0);
        else if (b == CH_DOT) mode = SCAN_INTDOT;
        else begin
          int_done(pos);
          start_token(b, pos);
        end
      end
      SCAN_INTDOT: begin
        if (digit(b)) mode = SCAN_FLOAT;
        else begin
          int_done(prev);
          emit(0, K_DOT, '0, '0, prev, pos);
          start_token(b, pos);
        end
      end
      SCAN_FLOAT: begin
        if (!digit(b)) begin
          emit(0, K_FLOAT, '0, '0, tbeg, pos);
          start_token(b, pos);
        end
      end
      SCAN_WORD: begin
        if (alpha(b) || digit(b)) word_add(b);
        else begin
          word_done(pos);
          start_token(b, pos);
        end
      end
      default: start_token(b, pos);
    endcase
    if (nstep > 0) step_res[nstep - 1].last_of_run = 1'b1;
    for (int i = 0; i < nstep; i++) expected_words.push_back(step_res[i]);
    if (restart) clear_scan();
    else if (offs < 24'hFFFFFF) offs++;
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    errors = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      clear_scan();
    end else begin
      if (in_valid && in_ready) scan_byte(in_source_byte);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual kind %0d", $time,
                   out_token_kind);
        end else begin
          want = expected_words.pop_front();
          field_check("is_text", want.is_text, out_is_text);
          field_check("token_kind", want.token_kind, out_token_kind);
          field_check("text_byte", want.text_byte, out_text_byte);
          field_check("int_value", want.int_value, out_int_value);
          field_check("line_number", want.line_number, out_line_number);
          field_check("start_offset", want.start_offset, out_start_offset);
          field_check("span_length", want.span_length, out_span_length);
          field_check("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
module testbench import sst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_source_byte;
  logic               out_valid;
  logic               out_ready;
  logic               out_is_text;
  logic [6:0]         out_token_kind;
  logic [7:0]         out_text_byte;
  logic signed [31:0] out_int_value;
  logic [15:0]        out_line_number;
  logic [23:0]        out_start_offset;
  logic [11:0]        out_span_length;
  logic               out_last_of_run;
  int                 errors;
  int                 pending;
  int                 sent;
  int                 idle_cycles;
  bit                 in_calm;
  bit                 out_calm;

  script_source_tokenizer_top uut (.*);

  token_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(15) == 0) in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_keyword();
    int k;
    k = $urandom_range(KW_COUNT - 1);
    for (int i = KW_LEN[k] - 1; i >= 0; i--) send_byte(KW_TEXT[k][8 * i +: 8]);
  endtask

  task automatic send_name();
    int n;
    n = $urandom_range(1, $urandom_range(3) == 0 ? 12 : 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_byte(8'(CH_LA + $urandom_range(25)));
        1: send_byte(8'(CH_UA + $urandom_range(25)));
        2: send_byte(8'(CH_0 + $urandom_range(9)));
        default: send_byte(CH_UNDER);
      endcase
    end
  endtask

  task automatic send_number();
    int n;
    if ($urandom_range(2) == 0) send_byte(CH_MINUS);
    n = $urandom_range(1, $urandom_range(4) == 0 ? 14 : 4);
    for (int i = 0; i < n; i++) send_byte(8'(CH_0 + $urandom_range(9)));
    if ($urandom_range(2) == 0) begin
      send_byte(CH_DOT);
      if ($urandom_range(1)) send_byte(8'(CH_0 + $urandom_range(9)));
    end
  endtask

  task automatic send_string(int n);
    send_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) begin
        send_byte(CH_BSLASH);
        case ($urandom_range(3))
          0: send_byte(CH_LN);
          1: send_byte(CH_LTT);
          2: send_byte(CH_QUOTE);
          default: send_byte(8'($urandom_range(1, 255)));
        endcase
      end else begin
        send_byte(8'($urandom_range(1, 255)) == CH_QUOTE ? CH_SPACE : 8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(7) != 0) send_byte(CH_QUOTE);
  endtask

  task automatic send_snippet();
    case ($urandom_range(15))
      0, 1:  send_keyword();
      2, 3:  send_name();
      4, 5:  send_number();
      6:     send_string($urandom_range(0, 6));
      7:     send_text($urandom_range(1) ? "==" : "!=");
      8: begin
        case ($urandom_range(5))
          0: send_text("<=");
          1: send_text(">=");
          2: send_text("+=");
          3: send_text("-=");
          4: send_text("&&");
          default: send_text("||");
        endcase
      end
      9:     send_byte(8'($urandom_range(33, 126)));
      10:    send_byte($urandom_range(1) ? CH_LF : CH_SPACE);
      11:    send_text($urandom_range(1) ? "# note\n" : "// note\n");
      12:    send_byte(8'($urandom_range(255)));
      13:    send_byte($urandom_range(1) ? CH_TAB : CH_CR);
      14:    if ($urandom_range(5) == 0) send_byte(CH_NUL); else send_byte(CH_SEMI);
      default: begin
        if ($urandom_range(7) == 0) send_string($urandom_range(125, 130));
        else send_byte(CH_SPACE);
      end
    endcase
    if ($urandom_range(1)) send_byte(CH_SPACE);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      int gap;
      if ($urandom_range(15) == 0) out_calm = ~out_calm;
      gap = out_calm ? 0 : $urandom_range(3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sent = 0;
    idle_cycles = 0;
    in_calm = 0;
    out_calm = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_source_byte <= CH_NUL;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("let true false x_1 functions\n");
    send_text("-12 12.a 3.14 2147483648 4294967297;");
    send_text("== != <= >= += -= && || & | !x -y //c\n#c\n");
    send_text("+*/%=<>(){}[],.:;@");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("\"a\\n\\t\\q\\\\\"");
    send_byte(CH_NUL);
    send_text("\"ab\\");
    send_byte(CH_NUL);
    send_string(127);
    send_text("7 \"open");
    send_byte(CH_NUL);

    while (sent < 350) send_snippet();
    send_byte(CH_NUL);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sst_pkg.sv
rtl/sst_scan.sv
rtl/sst_outq.sv
rtl/script_source_tokenizer_top.sv
rtl/sst_checker.sv
tb/token_checker.sv
tb/testbench.sv
